@@ rtl/core/crlfls_pkg.sv @@
// crlfls_pkg: shared types and constants for the crlf line splitter
// no dependencies; imported by crlfls_step, crlf_line_splitter_core and the dv checker and testbench
`default_nettype none

package crlfls_pkg;

    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_LF = 8'h0A;

    // line phase; the unused code behaves as an open line
    typedef enum logic [1:0] {
        PH_OPEN    = 2'd0,
        PH_RUN     = 2'd1,
        PH_DISCARD = 2'd2
    } phase_t;

    typedef struct packed {
        logic [7:0] byte_val;
        logic       has_byte;
        logic       line_done;
        logic       overflowed;
    } res_head_t;

endpackage

`default_nettype wire

@@ rtl/core/crlfls_step.sv @@
// crlfls_step: per-byte line framing decision, purely combinational
// depends on crlfls_pkg
`default_nettype none

module crlfls_step #(
    parameter int LINE_MAX = 512,
    parameter int LEN_W    = 10
) (
    input  wire logic                 binary_mode,
    input  wire crlfls_pkg::phase_t   phase,
    input  wire logic [LEN_W-1:0]     fill,
    input  wire logic [7:0]           data_byte,
    input  wire logic                 chunk_end,
    output crlfls_pkg::res_head_t     r0_head,
    output logic      [LEN_W-1:0]     r0_len,
    output crlfls_pkg::res_head_t     r1_head,
    output logic      [LEN_W-1:0]     r1_len,
    output logic      [1:0]           n_res,
    output crlfls_pkg::phase_t        phase_next,
    output logic      [LEN_W-1:0]     fill_next
);
    import crlfls_pkg::*;

    localparam logic [LEN_W-1:0] LMAX  = LEN_W'(LINE_MAX);
    localparam logic [LEN_W-1:0] LMAX2 = LEN_W'(LINE_MAX + 2);

    logic             nl;
    logic             bin_clear;
    phase_t           bp;
    logic [LEN_W-1:0] bf;
    logic             bare;
    logic [LEN_W-1:0] base;
    logic [LEN_W-1:0] g;
    logic             bdone;

    assign nl = (data_byte == CHAR_CR) || (data_byte == CHAR_LF);

    always_comb begin
        r0_head    = '0;
        r1_head    = '0;
        r0_len     = '0;
        r1_len     = '0;
        n_res      = 2'd0;
        phase_next = phase;
        fill_next  = fill;
        bin_clear  = 1'b0;
        bp         = PH_OPEN;
        bf         = '0;
        bare       = 1'b0;
        base       = '0;
        g          = '0;
        bdone      = 1'b0;
        if (!binary_mode) begin
            if (phase == PH_DISCARD) begin
                if (nl) begin
                    phase_next = PH_RUN;
                end
            end else if (phase == PH_RUN && nl) begin
                phase_next = PH_RUN;
            end else begin
                phase_next = PH_OPEN;
                if (fill >= LMAX) begin
                    r0_head    = '{byte_val: 8'h00, has_byte: 1'b0, line_done: 1'b1,
                                   overflowed: 1'b1};
                    r0_len     = LMAX2;
                    n_res      = 2'd1;
                    fill_next  = '0;
                    phase_next = nl ? PH_RUN : PH_DISCARD;
                end else if (nl) begin
                    r0_head    = '{byte_val: 8'h00, has_byte: 1'b0, line_done: 1'b1,
                                   overflowed: 1'b0};
                    r0_len     = LEN_W'(fill + 2'd2);
                    n_res      = 2'd1;
                    fill_next  = '0;
                    phase_next = PH_RUN;
                end else begin
                    g         = LEN_W'(fill + 1'b1);
                    fill_next = g;
                    r0_head   = '{byte_val: data_byte, has_byte: 1'b1, line_done: 1'b0,
                                  overflowed: 1'b0};
                    r0_len    = g;
                    n_res     = 2'd1;
                    if (g >= LMAX && chunk_end) begin
                        r1_head   = '{byte_val: 8'h00, has_byte: 1'b0, line_done: 1'b1,
                                      overflowed: 1'b1};
                        r1_len    = LMAX2;
                        n_res     = 2'd2;
                        fill_next = '0;
                    end
                end
            end
            if (chunk_end && phase_next != PH_OPEN) begin
                phase_next = PH_OPEN;
                fill_next  = '0;
            end
        end else begin
            bin_clear = (phase != PH_OPEN && phase != PH_RUN) ||
                        (phase == PH_RUN && fill == '0);
            bp = bin_clear ? PH_OPEN : phase;
            bf = bin_clear ? '0 : fill;
            if (bp == PH_RUN && nl) begin
                g       = LEN_W'(bf + 1'b1);
                bdone   = (g >= LMAX2) || chunk_end;
                r0_head = '{byte_val: data_byte, has_byte: 1'b1, line_done: bdone,
                            overflowed: 1'b0};
                r0_len  = g;
                n_res   = 2'd1;
                phase_next = bdone ? PH_OPEN : PH_RUN;
                fill_next  = bdone ? '0 : g;
            end else begin
                bare  = (bp == PH_RUN) || (bf >= LMAX);
                base  = bare ? '0 : bf;
                g     = LEN_W'(base + 1'b1);
                bdone = nl ? (chunk_end || g >= LMAX2) : (chunk_end && g >= LMAX);
                if (bare) begin
                    r0_head = '{byte_val: 8'h00, has_byte: 1'b0, line_done: 1'b1,
                                overflowed: 1'b0};
                    r0_len  = bf;
                    r1_head = '{byte_val: data_byte, has_byte: 1'b1, line_done: bdone,
                                overflowed: 1'b0};
                    r1_len  = g;
                    n_res   = 2'd2;
                end else begin
                    r0_head = '{byte_val: data_byte, has_byte: 1'b1, line_done: bdone,
                                overflowed: 1'b0};
                    r0_len  = g;
                    n_res   = 2'd1;
                end
                phase_next = (!bdone && nl) ? PH_RUN : PH_OPEN;
                fill_next  = bdone ? '0 : g;
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/crlf_line_splitter_core.sv @@
// crlf_line_splitter_core: splits a chunked byte stream into CR LF framed lines
// an accepted byte waits in the input register; its results wait in the result register
// throughput: one byte per cycle unless the output stalls; a two-item byte holds back the next byte
// the output keeps a two-slot result register, drained one item per cycle while m_tready is high
// reset: synchronous active-low aresetn clears phase, fill, binary mode and all valids
// depends on crlfls_pkg and crlfls_step
`default_nettype none

module crlf_line_splitter_core #(
    parameter  int LINE_MAX = 512,
    localparam int LEN_W    = $clog2(LINE_MAX + 3),
    localparam int TDATA_W  = ((10 + LEN_W + 7) / 8) * 8
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_we,
    input  wire logic               cfg_wdata,     // binary_mode
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [7:0]         s_tdata,       // data_byte
    input  wire logic               s_tlast,       // chunk_end
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [TDATA_W-1:0]      m_tdata,       // out_byte, line_done, overflowed, line_length
    output logic                    m_tuser,       // has_byte
    output logic                    m_tlast        // last
);
    import crlfls_pkg::*;

    logic             binary_mode_reg;
    phase_t           phase_reg, phase_next;
    logic [LEN_W-1:0] fill_reg, fill_next;

    logic             in_valid_reg;
    logic [7:0]       in_byte_reg;
    logic             in_ce_reg;

    res_head_t        slot0_head_reg, slot1_head_reg;
    logic [LEN_W-1:0] slot0_len_reg, slot1_len_reg;
    logic             slot0_last_reg, slot1_last_reg;
    logic [1:0]       out_cnt_reg;

    res_head_t        r0_head, r1_head;
    logic [LEN_W-1:0] r0_len, r1_len;
    logic [1:0]       n_res;

    logic             out_fire;
    logic             proc_fire;
    logic             in_fire;
    logic [TDATA_W-1:0] tdata_w;

    crlfls_step #(
        .LINE_MAX (LINE_MAX),
        .LEN_W    (LEN_W)
    ) u_step (
        .binary_mode (binary_mode_reg),
        .phase       (phase_reg),
        .fill        (fill_reg),
        .data_byte   (in_byte_reg),
        .chunk_end   (in_ce_reg),
        .r0_head     (r0_head),
        .r0_len      (r0_len),
        .r1_head     (r1_head),
        .r1_len      (r1_len),
        .n_res       (n_res),
        .phase_next  (phase_next),
        .fill_next   (fill_next)
    );

    assign m_tvalid  = (out_cnt_reg != 2'd0);
    assign out_fire  = m_tvalid && m_tready;
    assign proc_fire = in_valid_reg &&
                       ((out_cnt_reg == 2'd0) || (out_cnt_reg == 2'd1 && m_tready));
    assign s_tready  = !in_valid_reg || proc_fire;
    assign in_fire   = s_tvalid && s_tready;

    always_comb begin
        tdata_w                = '0;
        tdata_w[7:0]           = slot0_head_reg.byte_val;
        tdata_w[8]             = slot0_head_reg.line_done;
        tdata_w[9]             = slot0_head_reg.overflowed;
        tdata_w[10 +: LEN_W]   = slot0_len_reg;
    end

    assign m_tdata = tdata_w;
    assign m_tuser = slot0_head_reg.has_byte;
    assign m_tlast = slot0_last_reg;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (in_fire) begin
            in_valid_reg <= 1'b1;
        end else if (proc_fire) begin
            in_valid_reg <= 1'b0;
        end
        if (in_fire) begin
            in_byte_reg <= s_tdata;
            in_ce_reg   <= s_tlast;
        end
    end

    // line state and mode
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            binary_mode_reg <= 1'b0;
            phase_reg       <= PH_OPEN;
            fill_reg        <= '0;
        end else if (cfg_we) begin
            binary_mode_reg <= cfg_wdata;
            phase_reg       <= PH_OPEN;
            fill_reg        <= '0;
        end else if (proc_fire) begin
            phase_reg <= phase_next;
            fill_reg  <= fill_next;
        end
    end

    // two-slot result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_cnt_reg <= 2'd0;
        end else if (proc_fire) begin
            out_cnt_reg <= n_res;
        end else if (out_fire) begin
            out_cnt_reg <= out_cnt_reg - 2'd1;
        end
        if (proc_fire) begin
            slot0_head_reg <= r0_head;
            slot0_len_reg  <= r0_len;
            slot0_last_reg <= (n_res == 2'd1);
            slot1_head_reg <= r1_head;
            slot1_len_reg  <= r1_len;
            slot1_last_reg <= 1'b1;
        end else if (out_fire) begin
            slot0_head_reg <= slot1_head_reg;
            slot0_len_reg  <= slot1_len_reg;
            slot0_last_reg <= slot1_last_reg;
        end
    end

`ifndef SYNTHESIS
    a_discard_text_only: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_DISCARD) |-> !binary_mode_reg)
        else $error("discard phase in binary mode");

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= LEN_W'(LINE_MAX + 1))
        else $error("line fill beyond limit");

    a_bare_is_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> slot0_head_reg.line_done)
        else $error("bare item without line end");

    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_cnt_reg == 2'd2) |-> (!slot0_last_reg && slot1_last_reg))
        else $error("result slots out of order");
`endif

endmodule

`default_nettype wire

@@ dv/crlf_line_splitter_core_checker.sv @@
// crlf_line_splitter_core_checker: watches the byte and line channels, predicts every line item
// and compares it field by field with what the block delivers; reports a mismatch count
// depends on crlfls_pkg for the phase codes and the CR/LF constants
module crlf_line_splitter_core_checker #(
    parameter int LINE_MAX = 512,
    parameter int LEN_W    = $clog2(LINE_MAX + 3),
    parameter int TDATA_W  = ((10 + LEN_W + 7) / 8) * 8
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_we,
    input  wire logic               cfg_wdata,
    input  wire logic               s_tvalid,
    input  wire logic               s_tready,
    input  wire logic [7:0]         s_tdata,    // data_byte
    input  wire logic               s_tlast,    // chunk_end
    input  wire logic               m_tvalid,
    input  wire logic               m_tready,
    input  wire logic [TDATA_W-1:0] m_tdata,    // out_byte, line_done, overflowed, line_length
    input  wire logic               m_tuser,    // has_byte
    input  wire logic               m_tlast,    // last
    output int                      mismatch_cnt,
    output int                      pending_items
);
    import crlfls_pkg::*;

    typedef struct packed {
        logic [7:0]       out_byte;
        logic             has_byte;
        logic             line_done;
        logic             overflowed;
        logic [LEN_W-1:0] line_length;
        logic             last;
    } line_item_t;

    line_item_t framed_q[$];
    logic       binary_mode;
    phase_t     line_phase;
    int         line_fill;

    function automatic line_item_t mk_item(logic [7:0] b, logic has, logic done, logic ovf,
                                           int len);
        line_item_t it;
        it.out_byte    = b;
        it.has_byte    = has;
        it.line_done   = done;
        it.overflowed  = ovf;
        it.line_length = LEN_W'(len);
        it.last        = 1'b0;
        return it;
    endfunction

    function automatic void frame_byte(logic [7:0] b, logic ce);
        line_item_t r[2];
        int         n;
        logic       nl;
        logic       done;
        n  = 0;
        nl = (b == CHAR_CR) || (b == CHAR_LF);
        if (!binary_mode) begin
            if (line_phase == PH_DISCARD) begin
                if (nl) line_phase = PH_RUN;
            end else if (line_phase == PH_RUN && nl) begin
                // terminator run byte dropped
            end else begin
                line_phase = PH_OPEN;
                if (line_fill >= LINE_MAX) begin
                    r[n] = mk_item(8'h00, 1'b0, 1'b1, 1'b1, LINE_MAX + 2);
                    n++;
                    line_fill  = 0;
                    line_phase = nl ? PH_RUN : PH_DISCARD;
                end else if (nl) begin
                    r[n] = mk_item(8'h00, 1'b0, 1'b1, 1'b0, line_fill + 2);
                    n++;
                    line_fill  = 0;
                    line_phase = PH_RUN;
                end else begin
                    line_fill++;
                    r[n] = mk_item(b, 1'b1, 1'b0, 1'b0, line_fill);
                    n++;
                    if (line_fill >= LINE_MAX && ce) begin
                        r[n] = mk_item(8'h00, 1'b0, 1'b1, 1'b1, LINE_MAX + 2);
                        n++;
                        line_fill = 0;
                    end
                end
            end
            if (ce && line_phase != PH_OPEN) begin
                line_phase = PH_OPEN;
                line_fill  = 0;
            end
        end else begin
            if (line_phase == PH_DISCARD || (line_phase == PH_RUN && line_fill == 0)) begin
                line_phase = PH_OPEN;
                line_fill  = 0;
            end
            if (line_phase == PH_RUN && nl) begin
                line_fill++;
                done = (line_fill >= LINE_MAX + 2) || ce;
                r[n] = mk_item(b, 1'b1, done, 1'b0, line_fill);
                n++;
                if (done) begin
                    line_phase = PH_OPEN;
                    line_fill  = 0;
                end
            end else begin
                if (line_phase == PH_RUN || line_fill >= LINE_MAX) begin
                    r[n] = mk_item(8'h00, 1'b0, 1'b1, 1'b0, line_fill);
                    n++;
                    line_phase = PH_OPEN;
                    line_fill  = 0;
                end
                line_fill++;
                if (nl) begin
                    line_phase = PH_RUN;
                    done = ce || (line_fill >= LINE_MAX + 2);
                end else begin
                    done = ce && (line_fill >= LINE_MAX);
                end
                r[n] = mk_item(b, 1'b1, done, 1'b0, line_fill);
                n++;
                if (done) begin
                    line_phase = PH_OPEN;
                    line_fill  = 0;
                end
            end
        end
        for (int i = 0; i < n; i++) begin
            if (i == n - 1) r[i].last = 1'b1;
            framed_q.push_back(r[i]);
        end
    endfunction

    function automatic int field_diff(string name, int want_v, int got_v);
        if (want_v != got_v) begin
            $display("%0t: %s expected %0d got %0d", $time, name, want_v, got_v);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge aclk) begin
        line_item_t got;
        line_item_t want;
        int         bad;
        if (!aresetn) begin
            framed_q.delete();
            binary_mode  = 1'b0;
            line_phase   = PH_OPEN;
            line_fill    = 0;
            mismatch_cnt = 0;
        end else begin
            if (cfg_we) begin
                binary_mode = cfg_wdata;
                line_phase  = PH_OPEN;
                line_fill   = 0;
            end
            if (s_tvalid && s_tready) frame_byte(s_tdata, s_tlast);
            if (m_tvalid && m_tready) begin
                got.out_byte    = m_tdata[7:0];
                got.line_done   = m_tdata[8];
                got.overflowed  = m_tdata[9];
                got.line_length = m_tdata[10 +: LEN_W];
                got.has_byte    = m_tuser;
                got.last        = m_tlast;
                if (framed_q.size() == 0) begin
                    $display("%0t: unexpected item, expected none got byte %0d len %0d",
                             $time, got.out_byte, got.line_length);
                    mismatch_cnt++;
                end else begin
                    want = framed_q.pop_front();
                    bad  = field_diff("out_byte", int'(want.out_byte), int'(got.out_byte))
                         + field_diff("has_byte", int'(want.has_byte), int'(got.has_byte))
                         + field_diff("line_done", int'(want.line_done),
                                      int'(got.line_done))
                         + field_diff("overflowed", int'(want.overflowed),
                                      int'(got.overflowed))
                         + field_diff("line_length", int'(want.line_length),
                                      int'(got.line_length))
                         + field_diff("last", int'(want.last), int'(got.last));
                    if (bad != 0) mismatch_cnt++;
                end
            end
        end
        pending_items = framed_q.size();
    end

endmodule

@@ dv/crlf_line_splitter_core_tb.sv @@
// crlf_line_splitter_core_tb: drives chunked byte streams in text and binary mode with random
// gaps and stalls on both sides; verdict from the checker's mismatch and pending counts
// depends on crlfls_pkg, crlf_line_splitter_core and crlf_line_splitter_core_checker
module crlf_line_splitter_core_tb;
    import crlfls_pkg::*;

    localparam int LINE_MAX = 512;
    localparam int LEN_W    = $clog2(LINE_MAX + 3);
    localparam int TDATA_W  = ((10 + LEN_W + 7) / 8) * 8;

    logic               aclk;
    logic               aresetn;
    logic               cfg_we;
    logic               cfg_wdata;
    logic               s_tvalid;
    logic               s_tready;
    logic [7:0]         s_tdata;
    logic               s_tlast;
    logic               m_tvalid;
    logic               m_tready;
    logic [TDATA_W-1:0] m_tdata;
    logic               m_tuser;
    logic               m_tlast;
    int                 mismatch_cnt;
    int                 pending_items;
    bit                 calm;

    crlf_line_splitter_core #(
        .LINE_MAX(LINE_MAX)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tlast(s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .m_tlast(m_tlast)
    );

    crlf_line_splitter_core_checker #(
        .LINE_MAX(LINE_MAX)
    ) line_chk (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tlast(s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .mismatch_cnt(mismatch_cnt),
        .pending_items(pending_items)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #3000000;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    initial begin
        int hold;
        m_tready = 1'b0;
        hold     = 0;
        forever begin
            @(negedge aclk);
            if (hold > 0) begin
                m_tready <= 1'b0;
                hold--;
            end else begin
                m_tready <= 1'b1;
                if (!calm && $urandom_range(0, 3) == 0) hold = pick_gap();
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic ce);
        int gap;
        gap = calm ? 0 : pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= ce;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (pending_items != 0) @(negedge aclk);
        repeat (6) @(negedge aclk);
    endtask

    task automatic write_mode(input logic m);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= m;
        @(negedge aclk);
        cfg_we    <= 1'b0;
    endtask

    // data bytes then a CR/LF run; wide lines sit around LINE_MAX with no stray terminators
    task automatic send_line(input int len, input bit wide, output int n);
        logic [7:0] b;
        logic       ce;
        int         run;
        calm = ($urandom_range(0, 4) == 0);
        n    = 0;
        for (int i = 0; i < len; i++) begin
            b = 8'($urandom_range(0, 255));
            if (wide) begin
                if (b == CHAR_CR || b == CHAR_LF) b = b ^ 8'h80;
                ce = (i == len - 1) ? 1'($urandom_range(0, 1)) :
                                      ($urandom_range(0, 99) == 0);
            end else begin
                ce = ($urandom_range(0, 15) == 0);
            end
            send_byte(b, ce);
            n++;
        end
        if (wide) run = $urandom_range(0, 4);
        else run = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 3);
        for (int i = 0; i < run; i++) begin
            b  = $urandom_range(0, 1) ? CHAR_CR : CHAR_LF;
            ce = ($urandom_range(0, 5) == 0);
            send_byte(b, ce);
            n++;
        end
    endtask

    initial begin
        int sent;
        int n;
        int wide_left;
        bit held;
        aresetn   = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = 8'h00;
        s_tlast   = 1'b0;
        calm      = 1'b0;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        for (int p = 0; p < 4; p++) begin
            write_mode(p[0]);
            calm = 1'b0;
            if (p == 0) begin
                send_byte(8'h00, 1'b0);
                send_byte(8'hFF, 1'b0);
                send_byte(CHAR_CR, 1'b0);
                send_byte(CHAR_LF, 1'b0);
                send_byte(CHAR_CR, 1'b0);
                send_byte(8'h41, 1'b0);
                send_byte(CHAR_LF, 1'b1);
                send_byte(CHAR_LF, 1'b0);
                send_byte(8'h55, 1'b1);
                send_byte(8'hAA, 1'b0);
                send_byte(CHAR_CR, 1'b1);
            end else if (p == 1) begin
                send_byte(8'h00, 1'b0);
                send_byte(CHAR_CR, 1'b0);
                send_byte(CHAR_LF, 1'b0);
                send_byte(8'h7F, 1'b0);
                send_byte(CHAR_LF, 1'b1);
                send_byte(CHAR_CR, 1'b0);
                send_byte(8'hFF, 1'b0);
                send_byte(CHAR_CR, 1'b0);
                send_byte(CHAR_LF, 1'b0);
                send_byte(8'h80, 1'b1);
                send_byte(CHAR_LF, 1'b0);
            end
            sent      = 0;
            wide_left = (p < 2) ? 1 : 0;
            held      = 1'b0;
            while (sent < 75 || wide_left > 0) begin
                if (wide_left > 0 && (sent >= 75 || $urandom_range(0, 15) == 0)) begin
                    send_line(LINE_MAX - 1 + $urandom_range(0, 3), 1'b1, n);
                    wide_left--;
                end else begin
                    send_line($urandom_range(0, 20), 1'b0, n);
                    sent += n;
                end
                if (!held && sent > 30) begin
                    drain();
                    held = 1'b1;
                end
            end
        end
        calm = 1'b0;
        drain();
        if (mismatch_cnt == 0 && pending_items == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
